/* design/mma_pkg.sv */
// mma_pkg: shared types, event codes and limits of the mouse motion accumulator
// used by the channel interfaces, controller, datapath and top level
package mma_pkg;

    // default sizing of the record store
    localparam int DEF_MOUSE_COUNT = 16;
    localparam int DEF_ACCUM_LIMIT = 2048;

    // the mouse index field addresses at most this many records
    localparam int MOUSE_FIELD_DEPTH = 16;

    // packet limits
    localparam int         PKT_LIMIT   = 127;
    localparam logic [7:0] STATUS_MARK = 8'h80;

    // event kinds
    localparam logic [2:0] KIND_MOTION_BTN = 3'd0;
    localparam logic [2:0] KIND_MOTION     = 3'd1;
    localparam logic [2:0] KIND_BUTTON     = 3'd2;
    localparam logic [2:0] KIND_READ       = 3'd3;
    localparam logic [2:0] KIND_OPEN       = 3'd4;

    // one input event
    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        mouse;
        logic signed [11:0] delta_x;
        logic signed [11:0] delta_y;
        logic [7:0]        new_buttons;
        logic [7:0]        clear_mask;
        logic [7:0]        toggle_mask;
    } event_t;

    // one result
    typedef struct packed {
        logic              notify;
        logic              packet_valid;
        logic              no_data;
        logic [7:0]        status_byte;
        logic signed [7:0] out_x;
        logic signed [7:0] out_y;
        logic              still_ready;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
    } cmd_t;

endpackage

/* design/mma_if.sv */
// mma channel interfaces: event, result and configuration channels
// depends on mma_pkg for the payload types
interface mma_req_if;
    logic              valid;
    logic              ready;
    mma_pkg::event_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mma_rsp_if;
    logic              valid;
    logic              ready;
    mma_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mma_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/mouse_motion_accumulator_unit.sv */
// mouse_motion_accumulator_unit: top level joining controller and datapath
// depends on mma_pkg, mma_if, mma_ctrl and mma_datapath
//
//   channel | modport | transfer carries
//   --------+---------+----------------------------------------------
//   req     | sink    | one event: kind, mouse, deltas, button masks
//   rsp     | source  | one result: flags, packet bytes, ready flag
//   cfg     | sink    | init_buttons write data, always ready
//
// each event is taken at the transfer edge, then the execute state reads, updates
// and writes the addressed record in the register store
// a new event is taken as the previous result transfers, so back-to-back
// traffic holds one event in flight at a time; a stalled rsp holds req off
// reset clears all records, init_buttons and the control state at once
module mouse_motion_accumulator_unit
#(
    parameter int MOUSE_COUNT = mma_pkg::DEF_MOUSE_COUNT,
    parameter int ACCUM_LIMIT = mma_pkg::DEF_ACCUM_LIMIT
)
(
    input  logic     clk,
    input  logic     rst_n,
    mma_req_if.sink  req,
    mma_rsp_if.source rsp,
    mma_cfg_if.sink  cfg
);

    mma_pkg::cmd_t cmd;
    logic          in_ready;
    logic          out_valid;

    // sequencing
    mma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // records and update logic
    mma_datapath
    #(
        .MOUSE_COUNT (MOUSE_COUNT),
        .ACCUM_LIMIT (ACCUM_LIMIT)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (req.data),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .result   (rsp.data)
    );

    // handshake outputs
    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign cfg.ready = 1'b1;

`ifndef SYNTH
    // at most one kind of outcome per result
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot0({rsp.data.notify, rsp.data.packet_valid, rsp.data.no_data}))
        else $error("more than one outcome flag set");

    // packet bytes are zero unless a packet was given
    a_empty_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.packet_valid) |->
        (rsp.data.out_x == '0 && rsp.data.out_y == '0 && rsp.data.status_byte == '0))
        else $error("packet bytes set without a packet");

    // one event in flight: no transfer in the cycle after a transfer
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("event taken while another executes");

    // a taken event yields a result once its execute state has passed
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> ##2 rsp.valid)
        else $error("no result after an event");
`endif

endmodule

/* design/mma_ctrl.sv */
// mma_ctrl: state machine sequencing accept, execute and result transfer
// depends on mma_pkg for the command struct
module mma_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output mma_pkg::cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    // take an event while idle, once the result register is free or being emptied
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.load_item = accept;
    assign cmd.exec      = (state_reg == S_EXEC);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb
    begin
        priority if (state_reg == S_EXEC)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/mma_datapath.sv */
// mma_datapath: event register, mouse record store, update logic, result register
// depends on mma_pkg for types, event codes and packet limits
module mma_datapath
#(
    parameter int MOUSE_COUNT = mma_pkg::DEF_MOUSE_COUNT,
    parameter int ACCUM_LIMIT = mma_pkg::DEF_ACCUM_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mma_pkg::cmd_t    cmd,
    input  mma_pkg::event_t  item,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data,
    output mma_pkg::result_t result
);

    // records beyond the reach of the index field are never addressed
    localparam int REC_DEPTH = (MOUSE_COUNT < mma_pkg::MOUSE_FIELD_DEPTH) ?
                               MOUSE_COUNT : mma_pkg::MOUSE_FIELD_DEPTH;
    localparam int IDX_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
    localparam int ACC_W = $clog2(ACCUM_LIMIT) + 2;
    localparam int SUM_W = ((ACC_W > 12) ? ACC_W : 12) + 1;

    localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(ACCUM_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [ACC_W-1:0] PKT_POS = ACC_W'(mma_pkg::PKT_LIMIT);
    localparam logic signed [ACC_W-1:0] PKT_NEG = -PKT_POS;

    mma_pkg::event_t         item_reg;
    mma_pkg::result_t        result_reg;
    mma_pkg::result_t        result_next;
    logic [7:0]              init_btn_reg;

    logic [7:0]              btn_reg [REC_DEPTH];
    logic signed [ACC_W-1:0] x_reg   [REC_DEPTH];
    logic signed [ACC_W-1:0] y_reg   [REC_DEPTH];
    logic                    rdy_reg [REC_DEPTH];

    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    logic [7:0]              old_btn;
    logic signed [ACC_W-1:0] old_x;
    logic signed [ACC_W-1:0] old_y;
    logic                    old_rdy;

    logic                    is_motion;
    logic [7:0]              mot_btn;
    logic signed [11:0]      mot_dx;
    logic signed [11:0]      mot_dy;
    logic                    changed;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [ACC_W-1:0] sat_x;
    logic signed [ACC_W-1:0] sat_y;
    logic signed [ACC_W-1:0] pkt_x;
    logic signed [ACC_W-1:0] pkt_y;
    logic signed [ACC_W-1:0] rem_x;
    logic signed [ACC_W-1:0] rem_y;

    logic                    wr_en;
    logic [7:0]              new_btn;
    logic signed [ACC_W-1:0] new_x;
    logic signed [ACC_W-1:0] new_y;
    logic                    new_rdy;

    assign result = result_reg;

    // record read at the addressed mouse
    assign in_range = (int'(item_reg.mouse) < MOUSE_COUNT);
    assign idx      = in_range ? item_reg.mouse[IDX_W-1:0] : '0;
    assign old_btn  = btn_reg[idx];
    assign old_x    = x_reg[idx];
    assign old_y    = y_reg[idx];
    assign old_rdy  = rdy_reg[idx];

    // motion operands for the three motion-like kinds
    always_comb
    begin
        is_motion = 1'b1;
        mot_dx    = item_reg.delta_x;
        mot_dy    = item_reg.delta_y;
        mot_btn   = old_btn;
        unique case (item_reg.kind)
            mma_pkg::KIND_MOTION_BTN:
            begin
                mot_btn = item_reg.new_buttons;
            end
            mma_pkg::KIND_MOTION:
            begin
                mot_btn = old_btn;
            end
            mma_pkg::KIND_BUTTON:
            begin
                mot_dx  = '0;
                mot_dy  = '0;
                mot_btn = (old_btn & ~item_reg.clear_mask) ^ item_reg.toggle_mask;
            end
            default:
            begin
                is_motion = 1'b0;
            end
        endcase
    end

    assign changed = (mot_dx != '0) || (mot_dy != '0) || (mot_btn != old_btn);

    // saturating accumulate
    assign sum_x = SUM_W'(old_x) + SUM_W'(mot_dx);
    assign sum_y = SUM_W'(old_y) + SUM_W'(mot_dy);

    always_comb
    begin
        priority if (sum_x > LIM_POS)
        begin
            sat_x = ACC_W'(LIM_POS);
        end
        else if (sum_x < LIM_NEG)
        begin
            sat_x = ACC_W'(LIM_NEG);
        end
        else
        begin
            sat_x = sum_x[ACC_W-1:0];
        end
    end

    always_comb
    begin
        priority if (sum_y > LIM_POS)
        begin
            sat_y = ACC_W'(LIM_POS);
        end
        else if (sum_y < LIM_NEG)
        begin
            sat_y = ACC_W'(LIM_NEG);
        end
        else
        begin
            sat_y = sum_y[ACC_W-1:0];
        end
    end

    // packet clamp and remainder
    always_comb
    begin
        priority if (old_x > PKT_POS)
        begin
            pkt_x = PKT_POS;
        end
        else if (old_x < PKT_NEG)
        begin
            pkt_x = PKT_NEG;
        end
        else
        begin
            pkt_x = old_x;
        end
        priority if (old_y > PKT_POS)
        begin
            pkt_y = PKT_POS;
        end
        else if (old_y < PKT_NEG)
        begin
            pkt_y = PKT_NEG;
        end
        else
        begin
            pkt_y = old_y;
        end
    end

    assign rem_x = old_x - pkt_x;
    assign rem_y = old_y - pkt_y;

    // record update and result per kind
    always_comb
    begin
        wr_en       = 1'b0;
        new_btn     = old_btn;
        new_x       = old_x;
        new_y       = old_y;
        new_rdy     = old_rdy;
        result_next = '0;
        if (in_range)
        begin
            if (is_motion)
            begin
                if (changed)
                begin
                    wr_en              = 1'b1;
                    new_btn            = mot_btn;
                    new_x              = sat_x;
                    new_y              = sat_y;
                    new_rdy            = 1'b1;
                    result_next.notify = 1'b1;
                end
            end
            else if (item_reg.kind == mma_pkg::KIND_READ)
            begin
                if (!old_rdy)
                begin
                    result_next.no_data = 1'b1;
                end
                else
                begin
                    wr_en                    = 1'b1;
                    new_x                    = rem_x;
                    new_y                    = rem_y;
                    new_rdy                  = (rem_x != '0) || (rem_y != '0);
                    result_next.packet_valid = 1'b1;
                    result_next.status_byte  = old_btn | mma_pkg::STATUS_MARK;
                    result_next.out_x        = pkt_x[7:0];
                    result_next.out_y        = pkt_y[7:0];
                end
            end
            else if (item_reg.kind == mma_pkg::KIND_OPEN)
            begin
                wr_en   = 1'b1;
                new_btn = init_btn_reg;
                new_x   = '0;
                new_y   = '0;
                new_rdy = 1'b0;
            end
            result_next.still_ready = new_rdy;
        end
    end

    // event and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_btn_reg <= '0;
        end
        else if (cfg_we)
        begin
            init_btn_reg <= cfg_data;
        end
    end

    // mouse record store, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REC_DEPTH; i++)
            begin
                btn_reg[i] <= '0;
                x_reg[i]   <= '0;
                y_reg[i]   <= '0;
                rdy_reg[i] <= 1'b0;
            end
        end
        else if (cmd.exec && wr_en)
        begin
            btn_reg[idx] <= new_btn;
            x_reg[idx]   <= new_x;
            y_reg[idx]   <= new_y;
            rdy_reg[idx] <= new_rdy;
        end
    end

endmodule

/* sim/tb.sv */
// tb: self-checking bench for mouse_motion_accumulator_unit, with an event-level
// predictor of the record store; depends on mma_pkg and the mma channel interfaces
module tb;

    localparam int N_MICE       = mma_pkg::DEF_MOUSE_COUNT;
    localparam int ACC_LIM      = mma_pkg::DEF_ACCUM_LIMIT;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;

    // kinds the block ignores
    localparam logic [2:0] KIND_RSVD_5 = 3'd5;
    localparam logic [2:0] KIND_RSVD_6 = 3'd6;
    localparam logic [2:0] KIND_RSVD_7 = 3'd7;

    logic clk;
    logic rst_n;

    mma_req_if req_ch ();
    mma_rsp_if rsp_ch ();
    mma_cfg_if cfg_ch ();

    mouse_motion_accumulator_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted record store and open-time buttons
    logic [7:0] mouse_buttons [N_MICE];
    int         mouse_x       [N_MICE];
    int         mouse_y       [N_MICE];
    bit         mouse_ready   [N_MICE];
    logic [7:0] init_btn;

    mma_pkg::result_t reports_due [$];
    int      fail_count = 0;
    bit      gaps_on    = 1'b1;
    bit      stalls_on  = 1'b1;
    int      hold_req   = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int saturate(int v, int lim);
        if (v < -lim)
            return -lim;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // motion update, returns whether the record changed
    function automatic logic apply_motion(int m, int dx, int dy, logic [7:0] btn);
        if (dx == 0 && dy == 0 && mouse_buttons[m] == btn)
            return 1'b0;
        mouse_buttons[m] = btn;
        mouse_x[m]       = saturate(mouse_x[m] + dx, ACC_LIM);
        mouse_y[m]       = saturate(mouse_y[m] + dy, ACC_LIM);
        mouse_ready[m]   = 1'b1;
        return 1'b1;
    endfunction

    // advance the predicted store by one event and give its report
    function automatic mma_pkg::result_t predict_report(mma_pkg::event_t ev);
        mma_pkg::result_t r;
        int      m;
        int      dx;
        int      dy;
        int      sx;
        int      sy;
        r  = '0;
        m  = int'(ev.mouse);
        dx = int'($signed(ev.delta_x));
        dy = int'($signed(ev.delta_y));
        if (m >= N_MICE)
            return r;
        case (ev.kind)
            mma_pkg::KIND_MOTION_BTN:
                r.notify = apply_motion(m, dx, dy, ev.new_buttons);
            mma_pkg::KIND_MOTION:
                r.notify = apply_motion(m, dx, dy, mouse_buttons[m]);
            mma_pkg::KIND_BUTTON:
                r.notify = apply_motion(m, 0, 0,
                               (mouse_buttons[m] & ~ev.clear_mask) ^ ev.toggle_mask);
            mma_pkg::KIND_READ:
                if (!mouse_ready[m])
                    r.no_data = 1'b1;
                else
                begin
                    sx             = saturate(mouse_x[m], mma_pkg::PKT_LIMIT);
                    sy             = saturate(mouse_y[m], mma_pkg::PKT_LIMIT);
                    mouse_x[m]     = mouse_x[m] - sx;
                    mouse_y[m]     = mouse_y[m] - sy;
                    mouse_ready[m] = (mouse_x[m] != 0) || (mouse_y[m] != 0);
                    r.packet_valid = 1'b1;
                    r.status_byte  = mouse_buttons[m] | mma_pkg::STATUS_MARK;
                    r.out_x        = sx[7:0];
                    r.out_y        = sy[7:0];
                end
            mma_pkg::KIND_OPEN:
            begin
                mouse_ready[m]   = 1'b0;
                mouse_x[m]       = 0;
                mouse_y[m]       = 0;
                mouse_buttons[m] = init_btn;
            end
            default: ;
        endcase
        r.still_ready = mouse_ready[m];
        return r;
    endfunction

    function automatic mma_pkg::event_t make_event(logic [2:0] kind, int m, int dx, int dy,
                                                   logic [7:0] nb, logic [7:0] clr,
                                                   logic [7:0] tog);
        mma_pkg::event_t ev;
        ev.kind        = kind;
        ev.mouse       = m[3:0];
        ev.delta_x     = dx[11:0];
        ev.delta_y     = dy[11:0];
        ev.new_buttons = nb;
        ev.clear_mask  = clr;
        ev.toggle_mask = tog;
        return ev;
    endfunction

    // mostly small deltas so reads drain, with extremes and full range mixed in
    function automatic logic [11:0] draw_delta();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 4095);
            1: v = $urandom_range(0, 1) ? 2047 : -2048;
            2: v = 0;
            default: v = $urandom_range(0, 300) - 150;
        endcase
        return v[11:0];
    endfunction

    // random event, biased towards a few mice and towards real changes
    function automatic mma_pkg::event_t draw_event();
        mma_pkg::event_t ev;
        int     roll;
        int     m;
        roll = $urandom_range(0, 99);
        m    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_MICE - 1)
                                           : $urandom_range(0, 3);
        ev = make_event(mma_pkg::KIND_READ, m, int'(draw_delta()), int'(draw_delta()),
                        8'($urandom), 8'($urandom), 8'($urandom));
        if (roll < 30)
        begin
            ev.kind = mma_pkg::KIND_MOTION_BTN;
            if ($urandom_range(0, 3) == 0)
            begin
                ev.new_buttons = mouse_buttons[m];
                ev.delta_x     = '0;
                ev.delta_y     = '0;
            end
        end
        else if (roll < 50)
        begin
            ev.kind = mma_pkg::KIND_MOTION;
            if ($urandom_range(0, 4) == 0)
            begin
                ev.delta_x = '0;
                ev.delta_y = '0;
            end
        end
        else if (roll < 65)
        begin
            ev.kind = mma_pkg::KIND_BUTTON;
            if ($urandom_range(0, 4) == 0)
            begin
                ev.clear_mask  = '0;
                ev.toggle_mask = '0;
            end
        end
        else if (roll < 90)
            ev.kind = mma_pkg::KIND_READ;
        else if (roll < 95)
            ev.kind = mma_pkg::KIND_OPEN;
        else
            ev.kind = 3'($urandom_range(int'(KIND_RSVD_5), int'(KIND_RSVD_7)));
        return ev;
    endfunction

    // offer one event after a random gap and predict it on transfer
    task automatic send_event(mma_pkg::event_t ev);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= ev;
        do
            @(negedge clk);
        while (req_ch.ready !== 1'b1);
        reports_due.push_back(predict_report(ev));
        @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_init_buttons(logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(negedge clk);
        while (cfg_ch.ready !== 1'b1);
        init_btn = value;
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding report
    task automatic wait_until_settled();
        req_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            send_event(draw_event());
            // occasional sender pause until the store is quiet
            if ($urandom_range(0, 79) == 0)
                wait_until_settled();
        end
    endtask

    task automatic check_field(string name, logic signed [15:0] want,
                               logic signed [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // corner cases: saturation, draining, unchanged events, reserved kinds, open
    task automatic test_directed();
        wait_until_settled();
        write_init_buttons(8'hA5);
        send_event(make_event(mma_pkg::KIND_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_BUTTON, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_OPEN, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_MOTION_BTN, 0, 2047, -2048, 8'h00, 8'hFF, 8'hFF));
        send_event(make_event(mma_pkg::KIND_MOTION_BTN, 0, 2047, -2048, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_MOTION, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
        send_event(make_event(mma_pkg::KIND_MOTION_BTN, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_BUTTON, 0, 0, 0, 8'h00, 8'hFF, 8'h3C));
        send_event(make_event(mma_pkg::KIND_BUTTON, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_MOTION, 15, -1, 1, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 15, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 15, 0, 0, 8'h00, 8'h00, 8'h00));
        // ready with no motion left gives an empty packet
        send_event(make_event(mma_pkg::KIND_BUTTON, 15, 0, 0, 8'h00, 8'h00, 8'h81));
        send_event(make_event(mma_pkg::KIND_READ, 15, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(KIND_RSVD_5, 0, 5, -5, 8'hFF, 8'hFF, 8'hFF));
        send_event(make_event(KIND_RSVD_6, 0, -2048, 2047, 8'h55, 8'hAA, 8'h55));
        send_event(make_event(KIND_RSVD_7, 0, 2047, 2047, 8'hAA, 8'h55, 8'hAA));
        send_event(make_event(mma_pkg::KIND_OPEN, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 0, 0, 0, 8'h00, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_MOTION_BTN, 7, -2048, 2047, 8'hFF, 8'h00, 8'h00));
        send_event(make_event(mma_pkg::KIND_READ, 7, 0, 0, 8'h00, 8'h00, 8'h00));
        wait_until_settled();
    endtask

    // random traffic under several open-time button settings
    task automatic test_settings_sweep();
        logic [7:0] settings [4];
        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = 8'($urandom);
        settings[3] = 8'($urandom);
        foreach (settings[i])
        begin
            wait_until_settled();
            write_init_buttons(settings[i]);
            random_phase(300);
        end
        wait_until_settled();
    endtask

    // no gaps and no stalls on either side
    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_phase(150);
        wait_until_settled();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // long result hold-off while events keep coming
    task automatic test_output_hold();
        wait_until_settled();
        hold_req = HOLD_CYCLES;
        gaps_on  = 1'b0;
        random_phase(24);
        gaps_on  = 1'b1;
        wait_until_settled();
    endtask

    // main sequence
    initial
    begin : run
        for (int i = 0; i < N_MICE; i++)
        begin
            mouse_buttons[i] = '0;
            mouse_x[i]       = 0;
            mouse_y[i]       = 0;
            mouse_ready[i]   = 1'b0;
        end
        init_btn = '0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings_sweep();
        test_back_to_back();
        test_output_hold();

        wait_until_settled();
        if (fail_count == 0 && reports_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result receiver with random stalls and the long hold-off, checks each transfer
    initial
    begin : result_checker
        int      stall;
        int      n;
        mma_pkg::result_t got;
        mma_pkg::result_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall = stalls_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            // wait for the next transfer, applying a hold-off when asked
            forever
            begin
                @(negedge clk);
                if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                    break;
                if (hold_req > 0)
                begin
                    n        = hold_req;
                    hold_req = 0;
                    @(posedge clk);
                    rsp_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                    rsp_ch.ready <= 1'b1;
                end
            end
            got = rsp_ch.data;
            if (reports_due.size() == 0)
            begin
                $error("result transfer with no report outstanding");
                fail_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("notify", want.notify, got.notify);
                check_field("packet_valid", want.packet_valid, got.packet_valid);
                check_field("no_data", want.no_data, got.no_data);
                check_field("status_byte", want.status_byte, got.status_byte);
                check_field("out_x", want.out_x, got.out_x);
                check_field("out_y", want.out_y, got.out_y);
                check_field("still_ready", want.still_ready, got.still_ready);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $error("no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
design/mma_pkg.sv
design/mma_if.sv
design/mma_ctrl.sv
design/mma_datapath.sv
design/mouse_motion_accumulator_unit.sv
sim/tb.sv
